FILE: rtl/sfc_pkg.sv
// sfc_pkg: shared types and constants for the sphere frustum cull unit
// plane register layout, lane count and configuration register indexes
// no dependencies
`default_nettype none

package sfc_pkg;

   // plane register fields
   localparam int NORM_W     = 14;   // signed Q1.12 normal component
   localparam int OFFS_W     = 22;   // signed offset, units of 1/16
   localparam int OFFS_SHIFT = 12;   // offset scaled into the Q1.12 product domain
   localparam int PLANE_W    = 64;

   // sphere fields
   localparam int RADIUS_W  = 48;
   localparam int RSQ_SHIFT = 24;    // radius squared to the d squared domain
   localparam int FAR_W     = 2;

   // plane storage and test lanes
   localparam int NUM_PLANES  = 8;
   localparam int PLANE_IDX_W = 3;
   localparam int NUM_LANES   = 6;   // five fixed planes and one far plane
   localparam int FIXED_LANES = 5;
   localparam int FAR_LANE    = 5;

   // configuration port
   localparam int CSR_IDX_W = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_LEFT   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_RIGHT  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_BOTTOM = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_TOP    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NEAR   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_FAR_A  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_FAR_B  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_FAR_C  = 4'd7;

   // far plane choice codes; any other code picks the third far plane
   localparam logic [FAR_W-1:0] FAR_SEL_A = 2'd0;
   localparam logic [FAR_W-1:0] FAR_SEL_B = 2'd1;

   typedef struct packed {
      logic signed [OFFS_W-1:0] offset;
      logic signed [NORM_W-1:0] nz;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nx;
   } plane_type;

endpackage : sfc_pkg

`default_nettype wire

FILE: rtl/sphere_frustum_cull_unit.sv
// sphere_frustum_cull_unit: pipelined sphere against six plane frustum test
// depends on sfc_pkg (plane layout, lane count, register indexes)
`default_nettype none

//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  req     | in        | req_valid/req_ready   | center_x/y/z, radius_sq, far_choice
//  rsp     | out       | rsp_valid/rsp_ready   | visible
//  csr     | in        | csr_valid/csr_ready   | csr_index (plane 0..7), csr_wdata (packed plane)
//
//  one transaction per cycle sustained while the receiver holds rsp_ready high
//  the squaring of the distance is split into halves over two stages
//  reset clears all stage valid bits and the eight plane registers
//  a stall holds each full stage whose successor cannot load; bubbles are squeezed out
//  csr writes are always taken; index beyond seven is dropped

module sphere_frustum_cull_unit #(
   parameter int COORD_BITS = 24
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  signed [COORD_BITS-1:0]      req_center_x,
   input  wire  signed [COORD_BITS-1:0]      req_center_y,
   input  wire  signed [COORD_BITS-1:0]      req_center_z,
   input  wire  [sfc_pkg::RADIUS_W-1:0]      req_radius_sq,
   input  wire  [sfc_pkg::FAR_W-1:0]         req_far_choice,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic                              rsp_visible,
   // configuration channel
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [sfc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [sfc_pkg::PLANE_W-1:0]       csr_wdata
);

   import sfc_pkg::*;

   // datapath widths
   localparam int PW   = NORM_W + COORD_BITS;                   // one normal times coordinate
   localparam int SUMW = (PW + 2 > OFFS_W + OFFS_SHIFT) ? PW + 2 : OFFS_W + OFFS_SHIFT;
   localparam int DW   = SUMW + 1;                              // signed distance
   localparam int HW   = (DW + 1) / 2;                          // half of the magnitude
   localparam int SQW  = 2 * HW;                                // padded magnitude, one partial
   localparam int FW   = 2 * SQW;                               // full squared magnitude
   localparam int RW   = RADIUS_W + RSQ_SHIFT;                  // scaled radius squared
   localparam int CW   = (FW > RW) ? FW : RW;                   // compare width
   localparam int NSTG = 5;                                     // stages before output reg

   // ---------------------------------------------------------------------------------------
   // plane registers
   // ---------------------------------------------------------------------------------------
   plane_type plane_ff [NUM_PLANES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            plane_ff[p] <= '0;
         end
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_PLANES))) begin
         plane_ff[csr_index[PLANE_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage flow control: a stage loads when empty or when its contents move on
   // ---------------------------------------------------------------------------------------
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic [NSTG:0]   load;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            rsp_visible_ff;
   logic            rsp_visible_in;

   always_comb begin
      load[NSTG] = !rsp_valid_ff || rsp_ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign req_ready = load[0];

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
      rsp_valid_in = load[NSTG] ? valid_ff[NSTG-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 1: captured request
   // ---------------------------------------------------------------------------------------
   logic signed [COORD_BITS-1:0] s1_cx_ff, s1_cy_ff, s1_cz_ff;
   logic [RADIUS_W-1:0]          s1_r2_ff;
   logic [FAR_W-1:0]             s1_far_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_cx_ff  <= req_center_x;
         s1_cy_ff  <= req_center_y;
         s1_cz_ff  <= req_center_z;
         s1_r2_ff  <= req_radius_sq;
         s1_far_ff <= req_far_choice;
      end
   end

   // per lane plane pick and the three normal products
   plane_type               lane_plane [NUM_LANES];
   logic signed [PW-1:0]    s2_px_in [NUM_LANES];
   logic signed [PW-1:0]    s2_py_in [NUM_LANES];
   logic signed [PW-1:0]    s2_pz_in [NUM_LANES];

   always_comb begin
      for (int i = 0; i < FIXED_LANES; i++) begin
         lane_plane[i] = plane_ff[i];
      end
      case (s1_far_ff)
         FAR_SEL_A: lane_plane[FAR_LANE] = plane_ff[CSR_PLANE_FAR_A[PLANE_IDX_W-1:0]];
         FAR_SEL_B: lane_plane[FAR_LANE] = plane_ff[CSR_PLANE_FAR_B[PLANE_IDX_W-1:0]];
         default:   lane_plane[FAR_LANE] = plane_ff[CSR_PLANE_FAR_C[PLANE_IDX_W-1:0]];
      endcase
      for (int i = 0; i < NUM_LANES; i++) begin
         s2_px_in[i] = PW'(lane_plane[i].nx) * PW'(s1_cx_ff);
         s2_py_in[i] = PW'(lane_plane[i].ny) * PW'(s1_cy_ff);
         s2_pz_in[i] = PW'(lane_plane[i].nz) * PW'(s1_cz_ff);
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 2: products per lane
   // ---------------------------------------------------------------------------------------
   logic signed [PW-1:0]     s2_px_ff  [NUM_LANES];
   logic signed [PW-1:0]     s2_py_ff  [NUM_LANES];
   logic signed [PW-1:0]     s2_pz_ff  [NUM_LANES];
   logic signed [OFFS_W-1:0] s2_off_ff [NUM_LANES];
   logic [RADIUS_W-1:0]      s2_r2_ff;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            s2_px_ff[i]  <= s2_px_in[i];
            s2_py_ff[i]  <= s2_py_in[i];
            s2_pz_ff[i]  <= s2_pz_in[i];
            s2_off_ff[i] <= lane_plane[i].offset;
         end
         s2_r2_ff <= s1_r2_ff;
      end
   end

   // signed distance, its sign and its magnitude
   logic signed [DW-1:0] lane_dist [NUM_LANES];
   logic [NUM_LANES-1:0] s3_neg_in;
   logic [DW-1:0]        s3_mag_in [NUM_LANES];

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_dist[i] = DW'(s2_px_ff[i]) + DW'(s2_py_ff[i]) + DW'(s2_pz_ff[i])
                      + DW'($signed({s2_off_ff[i], {OFFS_SHIFT{1'b0}}}));
         s3_neg_in[i] = lane_dist[i][DW-1];
         // only used when negative; the most negative value maps to its true magnitude
         s3_mag_in[i] = DW'(-lane_dist[i]);
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 3: distance sign and magnitude
   // ---------------------------------------------------------------------------------------
   logic [NUM_LANES-1:0] s3_neg_ff;
   logic [DW-1:0]        s3_mag_ff [NUM_LANES];
   logic [RADIUS_W-1:0]  s3_r2_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_neg_ff <= s3_neg_in;
         for (int i = 0; i < NUM_LANES; i++) begin
            s3_mag_ff[i] <= s3_mag_in[i];
         end
         s3_r2_ff <= s2_r2_ff;
      end
   end

   // partial products of the square, magnitude split into high and low halves
   logic [SQW-1:0] lane_mag [NUM_LANES];
   logic [SQW-1:0] s4_ll_in [NUM_LANES];
   logic [SQW-1:0] s4_lh_in [NUM_LANES];
   logic [SQW-1:0] s4_hh_in [NUM_LANES];

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_mag[i] = SQW'(s3_mag_ff[i]);
         s4_ll_in[i] = SQW'(lane_mag[i][HW-1:0])   * SQW'(lane_mag[i][HW-1:0]);
         s4_lh_in[i] = SQW'(lane_mag[i][HW-1:0])   * SQW'(lane_mag[i][SQW-1:HW]);
         s4_hh_in[i] = SQW'(lane_mag[i][SQW-1:HW]) * SQW'(lane_mag[i][SQW-1:HW]);
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 4: partial products
   // ---------------------------------------------------------------------------------------
   logic [SQW-1:0]       s4_ll_ff [NUM_LANES];
   logic [SQW-1:0]       s4_lh_ff [NUM_LANES];
   logic [SQW-1:0]       s4_hh_ff [NUM_LANES];
   logic [NUM_LANES-1:0] s4_neg_ff;
   logic [RADIUS_W-1:0]  s4_r2_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            s4_ll_ff[i] <= s4_ll_in[i];
            s4_lh_ff[i] <= s4_lh_in[i];
            s4_hh_ff[i] <= s4_hh_in[i];
         end
         s4_neg_ff <= s3_neg_ff;
         s4_r2_ff  <= s3_r2_ff;
      end
   end

   // square reassembled at full width; the cross term appears twice
   logic [FW-1:0] s5_sq_in [NUM_LANES];

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         s5_sq_in[i] = (FW'(s4_hh_ff[i]) << (2 * HW)) + (FW'(s4_lh_ff[i]) << (HW + 1))
                     + FW'(s4_ll_ff[i]);
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 5: squared distance against scaled radius squared
   // ---------------------------------------------------------------------------------------
   logic [FW-1:0]        s5_sq_ff [NUM_LANES];
   logic [NUM_LANES-1:0] s5_neg_ff;
   logic [RADIUS_W-1:0]  s5_r2_ff;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            s5_sq_ff[i] <= s5_sq_in[i];
         end
         s5_neg_ff <= s4_neg_ff;
         s5_r2_ff  <= s4_r2_ff;
      end
   end

   // a lane culls when the center is behind the plane by more than the radius
   logic [CW-1:0]        radius_scaled;
   logic [NUM_LANES-1:0] lane_cull;

   always_comb begin
      radius_scaled = CW'({s5_r2_ff, {RSQ_SHIFT{1'b0}}});
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_cull[i] = s5_neg_ff[i] && (CW'(s5_sq_ff[i]) > radius_scaled);
      end
      rsp_visible_in = load[NSTG] ? !(|lane_cull) : rsp_visible_ff;
   end

   // ---------------------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      rsp_visible_ff <= rsp_visible_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   // ---------------------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------------------
   // a response only appears behind a full last stage
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(valid_ff[NSTG-1]))
      else $error("response raised without a full last stage");

   // a full stage that cannot move keeps its transaction
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !load[3]) |=> valid_ff[2])
      else $error("stalled stage dropped its transaction");

   // no lane behind its plane means the sphere is visible
   a_no_neg_visible: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NSTG-1] && load[NSTG] && (s5_neg_ff == '0)) |=> rsp_visible_ff)
      else $error("sphere culled with no negative distance");

   // an accepted request always lands in the first stage
   a_entry_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted request missing from first stage");

endmodule : sphere_frustum_cull_unit

`default_nettype wire

FILE: verif/sphere_frustum_cull_unit_test.sv
// sphere_frustum_cull_unit_test: self-checking bench for the sphere frustum cull unit
// directed spheres and plane writes, then random phases; visible from the table or a local predictor
// depends on sfc_pkg and the sphere_frustum_cull_unit top level

module sphere_frustum_cull_unit_test;
   import sfc_pkg::*;

   localparam int COORD_W     = 24;
   localparam int UNIT_NORM   = 1 << (NORM_W - 2);   // 1.0 in Q1.12
   localparam int RESET_CYCLES = 12;
   localparam int PHASE_ITEMS = 195;
   localparam int NUM_PHASES  = 10;
   localparam int TAIL_CYCLES = 24;                  // well past the depth of the pipeline
   // hang guard limit, set far above the slowest legal run
   localparam int CYCLE_LIMIT = 600000;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1);
   localparam logic signed [COORD_W-1:0] COORD_NEG = '1;   // minus one
   localparam logic [RADIUS_W-1:0]       R2_MAX    = '1;
   localparam logic [RADIUS_W-1:0]       R2_ONE    = RADIUS_W'(1);

   // far choice codes beyond the package ones; code three aliases the third far plane
   localparam logic [FAR_W-1:0] FAR_SEL_C     = 2'd2;
   localparam logic [FAR_W-1:0] FAR_SEL_SPARE = 2'd3;

   // register indexes past the plane file, which the block drops
   localparam logic [CSR_IDX_W-1:0] CSR_STRAY_FIRST = CSR_IDX_W'(NUM_PLANES);
   localparam logic [CSR_IDX_W-1:0] CSR_STRAY_LAST  = '1;

   // plane with normal +x and no offset, and one that sits behind every point
   localparam logic [PLANE_W-1:0] PLANE_UNIT_X = PLANE_W'(UNIT_NORM);
   localparam logic [PLANE_W-1:0] PLANE_BEHIND = {{OFFS_W{1'b1}}, {(PLANE_W-OFFS_W){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] cx, cy, cz;
      logic [RADIUS_W-1:0]       r2;
      logic [FAR_W-1:0]          fc;
   } sphere_type;

   typedef enum logic [0:0] {ROW_SPHERE, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {EXP_MODEL, EXP_VISIBLE, EXP_CULLED} row_check_type;

   typedef struct packed {
      row_kind_type         kind;
      row_check_type        check;
      logic [CSR_IDX_W-1:0] index;
      logic [PLANE_W-1:0]   data;
      sphere_type           sphere;
   } dir_row_type;

   typedef enum logic [2:0] {
      SHAPE_ZERO, SHAPE_ONES, SHAPE_MAXPOS, SHAPE_MINNEG, SHAPE_RANDOM, SHAPE_BOX, SHAPE_MIXED
   } plane_shape_type;

   typedef enum logic [1:0] {
      READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE
   } ready_mode_type;

   // dut side signals; the bench driven ones are at known values from time zero
   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   wire                         req_ready;
   logic signed [COORD_W-1:0]   req_center_x   = '0;
   logic signed [COORD_W-1:0]   req_center_y   = '0;
   logic signed [COORD_W-1:0]   req_center_z   = '0;
   logic [RADIUS_W-1:0]         req_radius_sq  = '0;
   logic [FAR_W-1:0]            req_far_choice = '0;
   wire                         rsp_valid;
   logic                        rsp_ready      = 1'b0;
   wire                         rsp_visible;
   logic                        csr_valid      = 1'b0;
   wire                         csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index      = '0;
   logic [PLANE_W-1:0]          csr_wdata      = '0;

   // predictor copy of the plane file and the visible flags still owed by the dut
   logic [PLANE_W-1:0] plane_shadow [NUM_PLANES];
   logic               visible_due [$];
   dir_row_type        dir_table [$];

   int error_count = 0;
   int rsp_count   = 0;
   int cycle_count = 0;
   int burst_left  = 0;

   // receiver stall generator state
   ready_mode_type ready_mode = READY_ALWAYS;
   int             ready_hold = 0;
   logic [15:0]    stall_bits = '1;
   logic [3:0]     stall_pos  = '0;

   plane_shape_type phase_shapes [NUM_PHASES] = '{
      SHAPE_ZERO, SHAPE_BOX, SHAPE_MAXPOS, SHAPE_BOX, SHAPE_MINNEG,
      SHAPE_RANDOM, SHAPE_MIXED, SHAPE_BOX, SHAPE_ONES, SHAPE_MIXED
   };

   sphere_frustum_cull_unit #(.COORD_BITS(COORD_W)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_center_z   (req_center_z),
      .req_radius_sq  (req_radius_sq),
      .req_far_choice (req_far_choice),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_visible    (rsp_visible),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // signed distance of the sphere center from one plane, in units of 2^-16
   function automatic longint plane_distance(logic [PLANE_W-1:0] word, sphere_type s);
      plane_type p;
      longint    nx, ny, nz, offs, cx, cy, cz;
      p    = word;
      nx   = $signed(p.nx);
      ny   = $signed(p.ny);
      nz   = $signed(p.nz);
      offs = $signed(p.offset);
      cx   = $signed(s.cx);
      cy   = $signed(s.cy);
      cz   = $signed(s.cz);
      return nx * cx + ny * cy + nz * cz + (offs <<< OFFS_SHIFT);
   endfunction

   // exact square of a negative distance, 128 bits so nothing wraps
   function automatic logic [127:0] distance_square(longint plane_dist);
      logic [63:0] mag;
      mag = -plane_dist;
      return {64'd0, mag} * {64'd0, mag};
   endfunction

   // sphere lies wholly on the negative side: d below zero and d squared past radius squared
   function automatic logic plane_rejects(logic [PLANE_W-1:0] word, sphere_type s);
      longint       plane_dist;
      logic [127:0] reach_sq;
      plane_dist = plane_distance(word, s);
      if (plane_dist >= 0) return 1'b0;
      reach_sq = {80'd0, s.r2} << RSQ_SHIFT;
      return distance_square(plane_dist) > reach_sq;
   endfunction

   function automatic int far_plane_of(logic [FAR_W-1:0] fc);
      case (fc)
         FAR_SEL_A: return CSR_PLANE_FAR_A;
         FAR_SEL_B: return CSR_PLANE_FAR_B;
         default:   return CSR_PLANE_FAR_C;
      endcase
   endfunction

   // five fixed planes plus the chosen far plane; any rejecting plane culls
   function automatic logic predict_visible(sphere_type s);
      logic culled;
      int   lane;
      culled = 1'b0;
      for (lane = 0; lane < FIXED_LANES; lane++)
         culled |= plane_rejects(plane_shadow[lane], s);
      culled |= plane_rejects(plane_shadow[far_plane_of(s.fc)], s);
      return !culled;
   endfunction

   // ---------------------------------------------------------------- stimulus shaping

   function automatic logic [PLANE_W-1:0] make_plane(plane_shape_type shape, int slot);
      plane_type p;
      int        axis, sgn, offs;
      int        norm [3];
      p = '0;
      if (shape == SHAPE_MIXED)
         shape = plane_shape_type'($urandom_range(int'(SHAPE_BOX), int'(SHAPE_ZERO)));
      case (shape)
         SHAPE_ONES: return '1;
         SHAPE_RANDOM: return {$urandom, $urandom};
         SHAPE_MAXPOS: begin
            p.nx     = {1'b0, {(NORM_W-1){1'b1}}};
            p.ny     = {1'b0, {(NORM_W-1){1'b1}}};
            p.nz     = {1'b0, {(NORM_W-1){1'b1}}};
            p.offset = {1'b0, {(OFFS_W-1){1'b1}}};
         end
         SHAPE_MINNEG: begin
            p.nx     = {1'b1, {(NORM_W-1){1'b0}}};
            p.ny     = {1'b1, {(NORM_W-1){1'b0}}};
            p.nz     = {1'b1, {(NORM_W-1){1'b0}}};
            p.offset = {1'b1, {(OFFS_W-1){1'b0}}};
         end
         SHAPE_BOX: begin
            // axis-aligned frustum: left/right on x, bottom/top on y, near and far on z
            axis = (slot < 2) ? 0 : (slot < 4) ? 1 : 2;
            sgn  = (slot == 1 || slot == 3 || slot >= FAR_LANE) ? -1 : 1;
            norm[0] = 0;
            norm[1] = 0;
            norm[2] = 0;
            norm[axis] = sgn * UNIT_NORM;
            // some planes lean a little so the dot product mixes axes
            if ($urandom_range(0, 3) == 0)
               norm[(axis + 1) % 3] = $urandom_range(0, 1024) - 512;
            offs = $urandom_range(0, 1 << 17);
            if ($urandom_range(0, 7) == 0) offs = -offs;
            p.nx     = norm[0][NORM_W-1:0];
            p.ny     = norm[1][NORM_W-1:0];
            p.nz     = norm[2][NORM_W-1:0];
            p.offset = offs[OFFS_W-1:0];
         end
         default: p = '0;
      endcase
      return p;
   endfunction

   function automatic logic signed [COORD_W-1:0] extreme_coord();
      case ($urandom_range(0, 4))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return '0;
         3:       return '1;
         default: return COORD_ONE;
      endcase
   endfunction

   function automatic sphere_type random_sphere();
      sphere_type   s;
      int           pick, lane;
      longint       plane_dist;
      logic [127:0] rim_sq;
      pick = $urandom_range(0, 9);
      s.fc = FAR_W'($urandom_range(0, 3));
      if (pick < 2) begin
         // full range, every bit of every field
         s.cx = COORD_W'($urandom);
         s.cy = COORD_W'($urandom);
         s.cz = COORD_W'($urandom);
         s.r2 = RADIUS_W'({$urandom, $urandom});
      end else if (pick < 3) begin
         s.cx = extreme_coord();
         s.cy = extreme_coord();
         s.cz = extreme_coord();
         case ($urandom_range(0, 2))
            0:       s.r2 = '0;
            1:       s.r2 = R2_MAX;
            default: s.r2 = R2_ONE;
         endcase
      end else begin
         // centers at frustum scale, radius of random magnitude
         s.cx = COORD_W'($urandom_range(0, 1 << 18) - (1 << 17));
         s.cy = COORD_W'($urandom_range(0, 1 << 18) - (1 << 17));
         s.cz = COORD_W'($urandom_range(0, 1 << 18) - (1 << 17));
         s.r2 = RADIUS_W'({$urandom, $urandom} >> $urandom_range(12, 47));
         // half of these put the sphere surface on or next to one used plane, if the center is behind it
         if ($urandom_range(0, 1) == 1) begin
            lane = $urandom_range(0, FAR_LANE);
            if (lane == FAR_LANE) lane = far_plane_of(s.fc);
            plane_dist = plane_distance(plane_shadow[lane], s);
            if (plane_dist < 0) begin
               rim_sq = distance_square(plane_dist) >> RSQ_SHIFT;
               if (rim_sq[127:RADIUS_W] != 0) begin
                  s.r2 = R2_MAX;
               end else begin
                  s.r2 = rim_sq[RADIUS_W-1:0];
                  case ($urandom_range(0, 2))
                     0:       if (s.r2 != '0) s.r2 = s.r2 - R2_ONE;
                     1:       if (s.r2 != R2_MAX) s.r2 = s.r2 + R2_ONE;
                     default: ;
                  endcase
               end
            end
         end
      end
      return s;
   endfunction

   function automatic void dir_sphere(logic signed [COORD_W-1:0] cx,
                                      logic signed [COORD_W-1:0] cy,
                                      logic signed [COORD_W-1:0] cz, logic [RADIUS_W-1:0] r2,
                                      logic [FAR_W-1:0] fc, row_check_type check);
      dir_row_type row;
      row        = '0;
      row.kind   = ROW_SPHERE;
      row.check  = check;
      row.sphere = '{cx: cx, cy: cy, cz: cz, r2: r2, fc: fc};
      dir_table.push_back(row);
   endfunction

   function automatic void dir_write(logic [CSR_IDX_W-1:0] index, logic [PLANE_W-1:0] data);
      dir_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.check = EXP_MODEL;
      row.index = index;
      row.data  = data;
      dir_table.push_back(row);
   endfunction

   // ---------------------------------------------------------------- drivers

   // request side: bursts of random length with random gaps; valid held until accepted
   task automatic send_sphere(sphere_type s, logic visible_want);
      int   gap;
      logic fire;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      visible_due.push_back(visible_want);
      req_valid      <= 1'b1;
      req_center_x   <= s.cx;
      req_center_y   <= s.cy;
      req_center_z   <= s.cz;
      req_radius_sq  <= s.r2;
      req_far_choice <= s.fc;
      // ready is looked at mid-cycle, the transaction happens at the next rising edge
      fire = 1'b0;
      while (!fire) begin
         @(negedge clock);
         fire = req_ready;
         @(posedge clock);
      end
   endtask

   // csr valid stays up across back to back writes; callers drop it afterwards
   task automatic write_plane(logic [CSR_IDX_W-1:0] index, logic [PLANE_W-1:0] data);
      logic fire;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      fire = 1'b0;
      while (!fire) begin
         @(negedge clock);
         fire = csr_ready;
         @(posedge clock);
      end
      if (index < CSR_IDX_W'(NUM_PLANES)) plane_shadow[index[PLANE_IDX_W-1:0]] = data;
   endtask

   // stop sending and let every owed response come back before touching the planes
   task automatic wait_idle();
      if (req_valid) req_valid <= 1'b0;
      while (visible_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // rewrite all eight planes for a new phase, with one dropped write mixed in
   task automatic load_planes(plane_shape_type shape);
      int                   slot, stray;
      logic [CSR_IDX_W-1:0] stray_index;
      wait_idle();
      stray       = $urandom_range(0, NUM_PLANES);
      stray_index = CSR_IDX_W'($urandom_range(int'(CSR_STRAY_LAST), int'(CSR_STRAY_FIRST)));
      for (slot = 0; slot < NUM_PLANES; slot++) begin
         if (slot == stray) write_plane(stray_index, {$urandom, $urandom});
         write_plane(slot[CSR_IDX_W-1:0], make_plane(shape, slot));
      end
      if (stray == NUM_PLANES) write_plane(stray_index, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // response side: the stall mode is picked anew whenever its hold runs out
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode = ready_mode_type'($urandom_range(int'(READY_SPARSE), int'(READY_ALWAYS)));
         ready_hold = $urandom_range(16, 256);
         stall_bits = 16'($urandom);
      end
      ready_hold--;
      stall_pos++;
      case (ready_mode)
         READY_ALWAYS:  rsp_ready <= 1'b1;
         READY_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
         READY_PATTERN: rsp_ready <= stall_bits[stall_pos];
         default:       rsp_ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic got, logic want);
      $display("visible check failed: %s, got %b want %b, response %0d, cycle %0d",
               what, got, want, rsp_count, cycle_count);
      error_count++;
   endtask

   // sampled mid-cycle; the response transaction completes at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (visible_due.size() == 0) begin
            report_mismatch("response with no sphere outstanding", rsp_visible, 1'bx);
         end else if (rsp_visible !== visible_due[0]) begin
            report_mismatch("wrong visible flag", rsp_visible, visible_due[0]);
            void'(visible_due.pop_front());
         end else begin
            void'(visible_due.pop_front());
         end
         rsp_count++;
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sphere_frustum_cull_unit: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      dir_row_type row;
      sphere_type  s;
      logic        want;
      int          phase, n;

      // out of reset every plane is zero, so nothing can be culled
      dir_sphere(COORD_MAX, COORD_MAX, COORD_MAX, '0, FAR_SEL_A, EXP_VISIBLE);
      dir_sphere(COORD_MIN, COORD_MIN, COORD_MIN, '0, FAR_SEL_B, EXP_VISIBLE);
      dir_sphere('0, '0, '0, R2_MAX, FAR_SEL_C, EXP_VISIBLE);
      dir_sphere(COORD_NEG, COORD_ONE, COORD_MIN, R2_ONE, FAR_SEL_SPARE, EXP_VISIBLE);
      dir_sphere(COORD_MIN, COORD_MAX, '0, R2_MAX, FAR_SEL_C, EXP_VISIBLE);
      // writes past the plane file must leave the planes at zero
      dir_write(CSR_STRAY_FIRST, '1);
      dir_write(CSR_STRAY_LAST, '1);
      dir_sphere('0, '0, '0, '0, FAR_SEL_A, EXP_VISIBLE);
      // left plane x >= 0: zero distance, d squared equal to radius squared, just outside, then inside
      dir_write(CSR_PLANE_LEFT, PLANE_UNIT_X);
      dir_sphere('0, COORD_MAX, COORD_MIN, '0, FAR_SEL_A, EXP_VISIBLE);
      dir_sphere(COORD_NEG, COORD_MIN, COORD_MAX, R2_ONE, FAR_SEL_B, EXP_VISIBLE);
      dir_sphere(COORD_NEG, '0, '0, '0, FAR_SEL_C, EXP_CULLED);
      dir_sphere(COORD_ONE, '0, '0, '0, FAR_SEL_SPARE, EXP_VISIBLE);
      // only the third far plane culls, reached by choice two and by choice three
      dir_write(CSR_PLANE_LEFT, '0);
      dir_write(CSR_PLANE_FAR_C, PLANE_BEHIND);
      dir_sphere('0, '0, '0, '0, FAR_SEL_C, EXP_CULLED);
      dir_sphere('0, '0, '0, '0, FAR_SEL_SPARE, EXP_CULLED);
      dir_sphere('0, '0, '0, '0, FAR_SEL_A, EXP_VISIBLE);
      dir_sphere('0, '0, '0, '0, FAR_SEL_B, EXP_VISIBLE);
      dir_sphere('0, '0, '0, R2_ONE, FAR_SEL_SPARE, EXP_VISIBLE);
      // extreme plane words against extreme spheres, left to the predictor
      dir_write(CSR_PLANE_FAR_A, '1);
      dir_write(CSR_PLANE_FAR_B, make_plane(SHAPE_MAXPOS, 0));
      dir_write(CSR_PLANE_NEAR, make_plane(SHAPE_MINNEG, 0));
      dir_sphere(COORD_MAX, COORD_MAX, COORD_MAX, R2_MAX, FAR_SEL_A, EXP_MODEL);
      dir_sphere(COORD_MIN, COORD_MIN, COORD_MIN, '0, FAR_SEL_B, EXP_MODEL);
      dir_sphere(COORD_MAX, COORD_MIN, COORD_NEG, R2_ONE, FAR_SEL_A, EXP_MODEL);
      dir_sphere('0, '0, '0, '0, FAR_SEL_B, EXP_MODEL);

      for (n = 0; n < NUM_PLANES; n++) plane_shadow[n] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_table[r]) begin
         row = dir_table[r];
         if (row.kind == ROW_WRITE) begin
            if (req_valid || visible_due.size() != 0) wait_idle();
            write_plane(row.index, row.data);
         end else begin
            if (csr_valid) csr_valid <= 1'b0;
            case (row.check)
               EXP_VISIBLE: want = 1'b1;
               EXP_CULLED:  want = 1'b0;
               default:     want = predict_visible(row.sphere);
            endcase
            send_sphere(row.sphere, want);
         end
      end

      // random phases, each under a fresh plane set
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         load_planes(phase_shapes[phase]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            s = random_sphere();
            send_sphere(s, predict_visible(s));
         end
      end

      // drain, then watch a while longer for stray responses
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("sphere_frustum_cull_unit: match");
      else
         $display("sphere_frustum_cull_unit: mismatch");
      $finish;
   end

endmodule
